[rtl/rotary_embedding_table_freq_unit_macros.svh]
// Assertion macros for the rotary embedding unit
`ifndef ROTARY_EMBEDDING_TABLE_FREQ_UNIT_MACROS_SVH
`define ROTARY_EMBEDDING_TABLE_FREQ_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RETF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`define RETF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define RETF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RETF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/retf_pkg.sv]
// Shared types, constants and the CORDIC angle table
package retf_pkg;
  localparam int PAIR_COUNT_DEF  = 64;
  localparam int ANGLE_STEPS_DEF = 24;
  localparam int PIDX_W = 6;
  localparam int CW = 34;  // CORDIC datapath width
  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30      = 34'sd1073741824;
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ROTATE = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           quad;
    logic [PIDX_W-1:0]    idx;
    logic signed [31:0]   a;
    logic signed [31:0]   b;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  function automatic logic [31:0] step_angle(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction
endpackage

[rtl/retf_if.sv]
// Input and result channel interfaces
interface retf_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [5:0]         pair_index;
  logic [19:0]        position;
  logic [31:0]        freq_turns;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  modport source (output valid, command, pair_index, position, freq_turns,
                  first_value, second_value, input ready);
  modport sink (input valid, command, pair_index, position, freq_turns,
                first_value, second_value, output ready);
endinterface

interface retf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rotated_first;
  logic signed [31:0] rotated_second;
  logic [5:0]         pair_echo;
  modport source (output valid, rotated_first, rotated_second, pair_echo,
                  input ready);
  modport sink (input valid, rotated_first, rotated_second, pair_echo,
                output ready);
endinterface

[rtl/rotary_embedding_table_freq_unit.sv]
// Top level: rotary position embedding with a loaded frequency table
//
//  channel  dir  words
//  in_s     in   load (command 0) or rotate (command 1)
//  out_s    out  one rotated pair per rotate word
//
// One word per cycle while out_s does not stall. Stages in order: table read,
// phase multiply, ANGLE_STEPS CORDIC stages, quadrant map, four products,
// rounding. Loads write the table at acceptance; a rotate right after a
// load to the same entry sees the new value. Reset clears only the
// pipeline valid bits. When out_s stalls, the whole pipeline holds.
`include "rotary_embedding_table_freq_unit_macros.svh"
module rotary_embedding_table_freq_unit import retf_pkg::*; #(
  parameter int PAIR_COUNT  = PAIR_COUNT_DEF,
  parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  retf_in_if.sink  in_s,
  retf_out_if.source out_s
);
  localparam int AW = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

  function automatic logic signed [31:0] finish(input logic signed [64:0] acc);
    logic signed [64:0] t;
    logic signed [34:0] r;
    t = acc + 65'sd536870912;
    r = 35'(t >>> 30);
    if (r > 35'sd2147483647)       return 32'sh7FFFFFFF;
    else if (r < -35'sd2147483648) return 32'sh80000000;
    else                           return r[31:0];
  endfunction

  function automatic logic signed [31:0] clamp1(input logic signed [CW-1:0] v);
    if (v > ONE_Q30)       return 32'sh40000000;
    else if (v < -ONE_Q30) return 32'shC0000000;
    else                   return v[31:0];
  endfunction

  logic en, acc_in, we, in_range;
  logic [AW-1:0] addr;
  logic [31:0] rdata;

  assign en       = !out_s.valid || out_s.ready;
  assign in_s.ready = en;
  assign acc_in   = in_s.valid && en;
  assign in_range = 32'(in_s.pair_index) < PAIR_COUNT;
  assign addr     = AW'(in_s.pair_index);
  assign we       = acc_in && in_s.command == CMD_LOAD && in_range;

  retf_freq_mem #(.PAIR_COUNT(PAIR_COUNT), .AW(AW)) u_mem (
    .clk(clk), .en(en), .we(we), .waddr(addr), .wdata(in_s.freq_turns),
    .raddr(addr), .rdata_r(rdata)
  );

  // stage 1: table read
  logic v1_r, inr1_r;
  logic [PIDX_W-1:0] idx1_r;
  logic [19:0] pos1_r;
  logic signed [31:0] a1_r, b1_r;
  // stage 2: phase
  logic v2_r;
  logic [PIDX_W-1:0] idx2_r;
  logic signed [31:0] a2_r, b2_r;
  logic [31:0] phase2_r, f1;
  logic [51:0] prod1;

  assign f1    = inr1_r ? rdata : 32'd0;
  assign prod1 = pos1_r * f1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc_in && in_s.command == CMD_ROTATE;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inr1_r   <= in_range;
      idx1_r   <= in_s.pair_index;
      pos1_r   <= in_s.position;
      a1_r     <= in_s.first_value;
      b1_r     <= in_s.second_value;
      idx2_r   <= idx1_r;
      a2_r     <= a1_r;
      b2_r     <= b1_r;
      phase2_r <= prod1[31:0];
    end
  end

  // quadrant reduction feeds the CORDIC chain
  cordic_t chain [0:ANGLE_STEPS];
  logic [31:0] phq, resid;

  assign phq   = phase2_r + 32'h20000000;
  assign resid = phase2_r - {phq[31:30], 30'd0};

  always_comb begin
    chain[0].valid = v2_r;
    chain[0].quad  = phq[31:30];
    chain[0].idx   = idx2_r;
    chain[0].a     = a2_r;
    chain[0].b     = b2_r;
    chain[0].x     = INV_GAIN_Q30;
    chain[0].y     = '0;
    chain[0].z     = CW'($signed(resid));
  end

  for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_step
    retf_cordic_step #(.STEP(k)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .d_i(chain[k]), .d_r(chain[k+1])
    );
  end

  // quadrant map and clamp
  cordic_t cf;
  logic signed [CW-1:0] cm, sm;
  logic vm_r;
  logic [PIDX_W-1:0] idxm_r;
  logic signed [31:0] am_r, bm_r, c_r, s_r;

  assign cf = chain[ANGLE_STEPS];
  always_comb begin
    case (cf.quad)
      2'd0:    begin cm = cf.x;  sm = cf.y;  end
      2'd1:    begin cm = -cf.y; sm = cf.x;  end
      2'd2:    begin cm = -cf.x; sm = -cf.y; end
      default: begin cm = cf.y;  sm = -cf.x; end
    endcase
  end

  // products, then rounding
  logic vp_r, out_v_r;
  logic [PIDX_W-1:0] idxp_r, idxo_r;
  logic signed [63:0] ac_r, bs_r, as_r, bc_r;
  logic signed [31:0] rf_r, rs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r    <= 1'b0;
      vp_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vm_r    <= cf.valid;
      vp_r    <= vm_r;
      out_v_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idxm_r <= cf.idx;
      am_r   <= cf.a;
      bm_r   <= cf.b;
      c_r    <= clamp1(cm);
      s_r    <= clamp1(sm);
      idxp_r <= idxm_r;
      ac_r   <= am_r * c_r;
      bs_r   <= bm_r * s_r;
      as_r   <= am_r * s_r;
      bc_r   <= bm_r * c_r;
      idxo_r <= idxp_r;
      rf_r   <= finish(65'(ac_r) - 65'(bs_r));
      rs_r   <= finish(65'(as_r) + 65'(bc_r));
    end
  end

  assign out_s.valid          = out_v_r;
  assign out_s.rotated_first  = rf_r;
  assign out_s.rotated_second = rs_r;
  assign out_s.pair_echo      = idxo_r;

  `RETF_ASSERT_NEXT(a_rot_enters, clk, rst_n, acc_in && in_s.command == CMD_ROTATE, v1_r)
  `RETF_ASSERT_NEXT(a_load_silent, clk, rst_n, acc_in && in_s.command == CMD_LOAD, !v1_r)
  `RETF_ASSERT_NEXT(a_stall_holds, clk, rst_n, !en, v1_r == $past(v1_r) && vp_r == $past(vp_r))
  `RETF_ASSERT_IMPL(a_clamped, clk, rst_n, vp_r, c_r <= 32'sh40000000 && c_r >= 32'shC0000000)
endmodule

[rtl/retf_freq_mem.sv]
// Frequency table memory, one write and one registered read port
module retf_freq_mem import retf_pkg::*; #(
  parameter int PAIR_COUNT = PAIR_COUNT_DEF,
  parameter int AW = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata_r
);
  logic [31:0] mem [0:PAIR_COUNT-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule

[rtl/retf_cordic_step.sv]
// One registered CORDIC rotation step
module retf_cordic_step import retf_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  cordic_t d_i,
  output cordic_t d_r
);
  localparam logic [4:0] SIDX = 5'(STEP);
  logic signed [CW-1:0] ang;
  logic signed [CW-1:0] dx, dy;
  cordic_t d_nxt;

  assign ang = $signed({2'b00, step_angle(SIDX)});
  assign dx  = d_i.y >>> STEP;
  assign dy  = d_i.x >>> STEP;

  always_comb begin
    d_nxt = d_i;
    if (!d_i.z[CW-1]) begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - ang;
    end else begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + ang;
    end
  end

  // only the valid bit is reset; the payload just follows it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r.valid <= d_i.valid;
    end
    if (en) begin
      d_r.quad <= d_nxt.quad;
      d_r.idx  <= d_nxt.idx;
      d_r.a    <= d_nxt.a;
      d_r.b    <= d_nxt.b;
      d_r.x    <= d_nxt.x;
      d_r.y    <= d_nxt.y;
      d_r.z    <= d_nxt.z;
    end
  end
endmodule

[verif/rotary_embedding_table_freq_unit_tb.sv]
// Testbench for the rotary embedding unit: self-predicting driver/monitor bench
module rotary_embedding_table_freq_unit_tb;
  import retf_pkg::*;

  typedef struct packed {
    logic               command;
    logic [5:0]         pair_index;
    logic [19:0]        position;
    logic [31:0]        freq_turns;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
  } word_t;

  typedef struct packed {
    logic signed [31:0] rotated_first;
    logic signed [31:0] rotated_second;
    logic [5:0]         pair_echo;
  } pair_t;

  localparam int LATENCY = ANGLE_STEPS_DEF + 6;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  retf_in_if in_ch();
  retf_out_if out_ch();

  rotary_embedding_table_freq_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_s(in_ch.sink), .out_s(out_ch.source)
  );

  word_t pending_words[$];
  pair_t expected_pairs[$];
  logic [31:0] freq_shadow[64];
  bit loaded[64];
  int mismatches = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int holdoff_cycles = 0;
  longint cycles = 0;
  bit stim_done = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [31:0] round_sat(longint acc);
    longint r;
    r = floor_shift(acc + (64'sd1 <<< 29), 30);
    r = clamp(r, -64'sd2147483648, 64'sd2147483647);
    return r[31:0];
  endfunction

  function automatic pair_t rotate_pair(word_t w, logic [31:0] freq);
    logic [31:0] phase, resid;
    logic [63:0] prod;
    logic [1:0] quad;
    longint x, y, z, dx, dy, c, s, a, b;
    pair_t p;
    prod = {44'd0, w.position} * {32'd0, freq};
    phase = prod[31:0];
    quad = 2'((phase + 32'h20000000) >> 30);
    resid = phase - ({30'd0, quad} << 30);
    z = longint'(signed'(resid));
    x = 652032874;
    y = 0;
    for (int i = 0; i < ANGLE_STEPS_DEF; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(step_angle(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(step_angle(5'(i)));
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = clamp(c, -64'sd1073741824, 64'sd1073741824);
    s = clamp(s, -64'sd1073741824, 64'sd1073741824);
    a = longint'(w.first_value);
    b = longint'(w.second_value);
    p.rotated_first = round_sat(a * c - b * s);
    p.rotated_second = round_sat(a * s + b * c);
    p.pair_echo = w.pair_index;
    return p;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 131072)) - 32'd65536;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_load(logic [5:0] idx, logic [31:0] freq);
    word_t w;
    w.command = CMD_LOAD;
    w.pair_index = idx;
    w.position = 20'($urandom());
    w.freq_turns = freq;
    w.first_value = $urandom();
    w.second_value = $urandom();
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic queue_rotate(logic [5:0] idx, logic [19:0] pos, logic [31:0] a,
                              logic [31:0] b);
    word_t w;
    w.command = CMD_ROTATE;
    w.pair_index = idx;
    w.position = pos;
    w.freq_turns = $urandom();
    w.first_value = a;
    w.second_value = b;
    pending_words.insert(pending_words.size(), w);
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  // driver: predicts at acceptance so loads and rotates stay in order
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.command == CMD_LOAD) begin
          freq_shadow[in_ch.pair_index] = in_ch.freq_turns;
        end else begin
          expected_pairs.insert(expected_pairs.size(), rotate_pair(
            {in_ch.command, in_ch.pair_index, in_ch.position, in_ch.freq_turns,
             in_ch.first_value, in_ch.second_value},
            freq_shadow[in_ch.pair_index]));
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() > 0 && $urandom_range(1, 100) > src_idle_pct) begin
          word_t w;
          w = pending_words.pop_front();
          in_ch.valid <= 1'b1;
          {in_ch.command, in_ch.pair_index, in_ch.position, in_ch.freq_turns,
           in_ch.first_value, in_ch.second_value} <= w;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off countdown
  always @(posedge clk) begin
    if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pairs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word pair_echo=%0d", out_ch.pair_echo);
        end else begin
          pair_t e;
          e = expected_pairs.pop_front();
          if (e.rotated_first !== out_ch.rotated_first ||
              e.rotated_second !== out_ch.rotated_second ||
              e.pair_echo !== out_ch.pair_echo) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %0d %0d %0d got %0d %0d %0d",
                       e.rotated_first, e.rotated_second, e.pair_echo,
                       out_ch.rotated_first, out_ch.rotated_second, out_ch.pair_echo);
          end
        end
      end
      if (holdoff_cycles > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(1, 100) > sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic run_phase(int idle, int stall, int count);
    int idx;
    src_idle_pct = idle;
    sink_stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        idx = $urandom_range(0, 63);
        queue_load(6'(idx), $urandom());
        loaded[idx] = 1;
      end else begin
        do idx = $urandom_range(0, 63); while (!loaded[idx]);
        queue_rotate(6'(idx), 20'($urandom()), rand_value(), rand_value());
      end
    end
    while (pending_words.size() > 0 || in_ch.valid) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOAD;
    in_ch.pair_index = '0;
    in_ch.position = '0;
    in_ch.freq_turns = '0;
    in_ch.first_value = '0;
    in_ch.second_value = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extreme frequencies, quarter turns, saturating values
    queue_load(6'd0, 32'h0);
    queue_load(6'd63, 32'hFFFFFFFF);
    queue_load(6'd1, 32'h40000000);
    queue_load(6'd2, 32'h20000000);
    queue_rotate(6'd0, 20'hFFFFF, 32'h7FFFFFFF, 32'h80000000);
    queue_rotate(6'd63, 20'hFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    queue_rotate(6'd63, 20'd0, 32'h80000000, 32'h80000000);
    for (int q = 0; q < 4; q++) queue_rotate(6'd1, 20'(q), 32'h00010000, 32'h0);
    for (int q = 0; q < 8; q++) queue_rotate(6'd2, 20'(q), 32'h7FFFFFFF, 32'h80000000);
    queue_load(6'd5, 32'h12345678);
    queue_rotate(6'd5, 20'd3, 32'hFFFFFFFF, 32'h00000001);
    queue_rotate(6'd5, 20'h55555, 32'h0, 32'h0);
    loaded[0] = 1; loaded[63] = 1; loaded[1] = 1; loaded[2] = 1; loaded[5] = 1;
    run_phase(0, 0, 0);
    for (int i = 0; i < 64; i++) if (!loaded[i]) begin
      queue_load(6'(i), $urandom());
      loaded[i] = 1;
    end

    run_phase(0, 0, 300);
    // long receiver hold-off while the sender keeps offering words
    holdoff_cycles = 200;
    run_phase(0, 0, 150);
    run_phase(75, 0, 300);
    run_phase(0, 75, 300);
    run_phase(37, 37, 250);

    while (expected_pairs.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_pairs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
